/* rtl/great_circle_initial_bearing_macros.svh */
// ----------------------------------------------------------------------------
// great circle initial bearing assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_INITIAL_BEARING_MACROS_SVH
`define GREAT_CIRCLE_INITIAL_BEARING_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define GCIB_CHK_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("gcib check failed");
// next-cycle implication
`define GCIB_CHK_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("gcib check failed");
`else
`define GCIB_CHK_IMPLY(lbl, ck, rn, ante, cons)
`define GCIB_CHK_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* rtl/gcib_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcib_pkg
// shared constants, tables and helpers for the bearing pipeline
// ----------------------------------------------------------------------------
package gcib_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int FRAC_BITS     = 30;

  // cordic gain, q30 source rescaled to FRAC_BITS
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint GAIN = (FRAC_BITS >= 30) ? (GAIN_Q30 <<< (FRAC_BITS - 30)) :
    ((GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
  localparam longint ONE  = 64'sd1 <<< FRAC_BITS;

  // datapath widths
  localparam int RW = FRAC_BITS + 4;   // sin/cos and products
  localparam int XW = FRAC_BITS + 5;   // x before vectoring
  localparam int VW = FRAC_BITS + 7;   // vectoring datapath
  localparam int ZW = 33;              // angle accumulator

  localparam logic [31:0] TURN_HALF = 32'h8000_0000;

  // latency of the cordic units
  localparam int ROT_LAT = CORDIC_STAGES + 2;
  localparam int VEC_LAT = CORDIC_STAGES + 2;

  // atan(2^-i) in turn units
  localparam logic [31:0] ATAN_TURN [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // product truncated toward zero
  function automatic logic signed [RW-1:0] mulq(input logic signed [RW-1:0] a,
                                                 input logic signed [RW-1:0] b);
    logic              neg;
    logic [RW-1:0]     ma;
    logic [RW-1:0]     mb;
    logic [2*RW-1:0]   p;
    logic [RW-1:0]     r;
    neg = a[RW-1] ^ b[RW-1];
    ma  = a[RW-1] ? RW'(-a) : RW'(a);
    mb  = b[RW-1] ? RW'(-b) : RW'(b);
    p   = (2*RW)'(ma) * (2*RW)'(mb);
    r   = p[FRAC_BITS +: RW];
    return neg ? RW'(-r) : RW'(r);
  endfunction

endpackage

/* rtl/gcib_cordic_rot.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcib_cordic_rot
// pipelined rotation cordic: turn angle in, sine and cosine out
// ----------------------------------------------------------------------------
module gcib_cordic_rot (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [31:0]                   in_angle,
  output logic                          out_valid,
  output logic signed [gcib_pkg::RW-1:0] out_sin,
  output logic signed [gcib_pkg::RW-1:0] out_cos
);
  import gcib_pkg::*;

  logic                 v_r    [0:CORDIC_STAGES];
  logic signed [RW-1:0] x_r    [0:CORDIC_STAGES];
  logic signed [RW-1:0] y_r    [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z_r    [0:CORDIC_STAGES];
  logic [1:0]           q_r    [0:CORDIC_STAGES];
  logic                 sp_r   [0:CORDIC_STAGES];
  logic                 flip_r [0:CORDIC_STAGES];

  logic                 flip_nxt;
  logic [31:0]          a_nxt;

  assign flip_nxt = in_angle[31] ^ in_angle[30];
  assign a_nxt    = flip_nxt ? {~in_angle[31], in_angle[30:0]} : in_angle;

  // fold into the right half plane
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    x_r[0]    <= RW'(GAIN);
    y_r[0]    <= '0;
    z_r[0]    <= ZW'(signed'(a_nxt));
    q_r[0]    <= in_angle[31:30];
    sp_r[0]   <= (in_angle[29:0] == '0);
    flip_r[0] <= flip_nxt;
  end

  genvar i;
  generate
    for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i+1] <= 1'b0;
        end else begin
          v_r[i+1] <= v_r[i];
        end
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ZW'(ATAN_TURN[i % 32]);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ZW'(ATAN_TURN[i % 32]);
        end
        q_r[i+1]    <= q_r[i];
        sp_r[i+1]   <= sp_r[i];
        flip_r[i+1] <= flip_r[i];
      end
    end
  endgenerate

  logic                 val_r;
  logic signed [RW-1:0] sin_r;
  logic signed [RW-1:0] cos_r;
  logic signed [RW-1:0] sin_nxt;
  logic signed [RW-1:0] cos_nxt;

  // exact values on quadrant boundaries
  always_comb begin
    sin_nxt = flip_r[CORDIC_STAGES] ? RW'(-y_r[CORDIC_STAGES]) : y_r[CORDIC_STAGES];
    cos_nxt = flip_r[CORDIC_STAGES] ? RW'(-x_r[CORDIC_STAGES]) : x_r[CORDIC_STAGES];
    if (sp_r[CORDIC_STAGES]) begin
      case (q_r[CORDIC_STAGES])
        2'd0: begin
          cos_nxt = RW'(ONE);
          sin_nxt = '0;
        end
        2'd1: begin
          cos_nxt = '0;
          sin_nxt = RW'(ONE);
        end
        2'd2: begin
          cos_nxt = RW'(-ONE);
          sin_nxt = '0;
        end
        default: begin
          cos_nxt = '0;
          sin_nxt = RW'(-ONE);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else begin
      val_r <= v_r[CORDIC_STAGES];
    end
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  assign out_valid = val_r;
  assign out_sin   = sin_r;
  assign out_cos   = cos_r;

endmodule

/* rtl/gcib_cordic_vec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcib_cordic_vec
// pipelined vectoring cordic: atan2(y, x) as a turn angle
// ----------------------------------------------------------------------------
module gcib_cordic_vec (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic signed [gcib_pkg::XW-1:0] in_x,
  input  logic signed [gcib_pkg::RW-1:0] in_y,
  output logic                          out_valid,
  output logic [31:0]                   out_angle
);
  import gcib_pkg::*;

  logic                 v_r    [0:CORDIC_STAGES];
  logic signed [VW-1:0] x_r    [0:CORDIC_STAGES];
  logic signed [VW-1:0] y_r    [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z_r    [0:CORDIC_STAGES];
  logic                 base_r [0:CORDIC_STAGES];
  logic                 sp_r   [0:CORDIC_STAGES];
  logic                 spv_r  [0:CORDIC_STAGES];

  logic signed [VW-1:0] x_ext;
  logic signed [VW-1:0] y_ext;

  assign x_ext = VW'(in_x);
  assign y_ext = VW'(in_y);

  // zero y is exact, left half plane is rotated by a half turn
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    sp_r[0]   <= (in_y == '0);
    spv_r[0]  <= in_x[XW-1];
    base_r[0] <= in_x[XW-1];
    x_r[0]    <= in_x[XW-1] ? VW'(-x_ext) : x_ext;
    y_r[0]    <= in_x[XW-1] ? VW'(-y_ext) : y_ext;
    z_r[0]    <= '0;
  end

  genvar i;
  generate
    for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i+1] <= 1'b0;
        end else begin
          v_r[i+1] <= v_r[i];
        end
        if (!y_r[i][VW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ZW'(ATAN_TURN[i % 32]);
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ZW'(ATAN_TURN[i % 32]);
        end
        base_r[i+1] <= base_r[i];
        sp_r[i+1]   <= sp_r[i];
        spv_r[i+1]  <= spv_r[i];
      end
    end
  endgenerate

  logic        val_r;
  logic [31:0] ang_r;
  logic [31:0] ang_nxt;

  always_comb begin
    if (sp_r[CORDIC_STAGES]) begin
      ang_nxt = spv_r[CORDIC_STAGES] ? TURN_HALF : '0;
    end else begin
      ang_nxt = z_r[CORDIC_STAGES][31:0] + (base_r[CORDIC_STAGES] ? TURN_HALF : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0;
    end else begin
      val_r <= v_r[CORDIC_STAGES];
    end
    ang_r <= ang_nxt;
  end

  assign out_valid = val_r;
  assign out_angle = ang_r;

endmodule

/* rtl/great_circle_initial_bearing.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_initial_bearing
// initial great-circle bearing between two positions, whole degrees 0..359
// ----------------------------------------------------------------------------
//
//  channel   ports                                        handshake
//  input     in_from_lat/lon, in_to_lat/lon               start && !busy
//  result    out_bearing_deg                              out_valid strobe
//
//  one transaction enters per clock; busy is always low
//  stages in order: angle conversion, the sine/cosine cordic, the products,
//  the atan2 cordic and conversion to degrees
//  the pipeline never stalls; every stage advances each clock
//  synchronous reset clears only the valid bits
//
module great_circle_initial_bearing (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_from_lat,
  input  logic signed [31:0] in_from_lon,
  input  logic signed [30:0] in_to_lat,
  input  logic signed [31:0] in_to_lon,
  output logic               out_valid,
  output logic [8:0]         out_bearing_deg
);
  import gcib_pkg::*;

`include "great_circle_initial_bearing_macros.svh"

  // 1e-7 degree to turn: round(m * 2^22 / 3515625)
  localparam logic [32:0] RECIP  = 33'd5124095576;  // floor(2^54 / 3515625)
  localparam logic [25:0] DIVSR  = 26'd3515625;
  localparam logic [25:0] HALF_D = 26'd1757812;
  localparam int          LAT    = 3 + ROT_LAT + 3 + VEC_LAT + 2;

  logic acc;
  assign busy = 1'b0;
  assign acc  = start && !busy;

  // ---- conversion lanes: start lat, target lat, longitude difference ----
  logic signed [32:0] lane_in [0:2];
  assign lane_in[0] = 33'(in_from_lat);
  assign lane_in[1] = 33'(in_to_lat);
  assign lane_in[2] = 33'(in_to_lon) - 33'(in_from_lon);

  logic [2:0]  cv_v_r;
  logic        neg1_r [0:2];
  logic [31:0] mag1_r [0:2];
  logic [32:0] q01_r  [0:2];
  logic        neg2_r [0:2];
  logic [32:0] q02_r  [0:2];
  logic [25:0] rem2_r [0:2];
  logic [31:0] turn_r [0:2];

  logic [31:0] mag_nxt [0:2];
  logic [64:0] prd_nxt [0:2];
  logic [25:0] rem_nxt [0:2];
  logic [32:0] q_nxt   [0:2];

  // per-lane arithmetic, lanes are independent
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_nxt[k] = lane_in[k][32] ? 32'(-lane_in[k]) : lane_in[k][31:0];
      prd_nxt[k] = 65'(mag_nxt[k]) * 65'(RECIP);
      // remainder is known to stay below three divisors
      rem_nxt[k] = {mag1_r[k][3:0], 22'd0} + HALF_D - (q01_r[k][25:0] * DIVSR);
      q_nxt[k]   = q02_r[k] + 33'(rem2_r[k] >= DIVSR) + 33'(rem2_r[k] >= {DIVSR[24:0], 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_v_r <= '0;
    end else begin
      cv_v_r <= {cv_v_r[1:0], acc};
    end
    for (int k = 0; k < 3; k++) begin
      neg1_r[k] <= lane_in[k][32];
      mag1_r[k] <= mag_nxt[k];
      q01_r[k]  <= prd_nxt[k][64:32];
      neg2_r[k] <= neg1_r[k];
      q02_r[k]  <= q01_r[k];
      rem2_r[k] <= rem_nxt[k];
      turn_r[k] <= neg2_r[k] ? (-q_nxt[k][31:0]) : q_nxt[k][31:0];
    end
  end

  // ---- sine and cosine of the three angles ----
  logic                 rot_v [0:2];
  logic signed [RW-1:0] sn    [0:2];
  logic signed [RW-1:0] cs    [0:2];

  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_rot
      gcib_cordic_rot u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv_v_r[2]),
        .in_angle  (turn_r[g]),
        .out_valid (rot_v[g]),
        .out_sin   (sn[g]),
        .out_cos   (cs[g])
      );
    end
  endgenerate

  // ---- products: y = sd*c2, x = c1*s2 - (s1*c2)*cd ----
  logic [2:0]           pr_v_r;
  logic signed [RW-1:0] y1_r;
  logic signed [RW-1:0] t1_r;
  logic signed [RW-1:0] u1_r;
  logic signed [RW-1:0] cd1_r;
  logic signed [RW-1:0] y2_r;
  logic signed [RW-1:0] t2_r;
  logic signed [RW-1:0] v2_r;
  logic signed [RW-1:0] y3_r;
  logic signed [XW-1:0] x3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= '0;
    end else begin
      pr_v_r <= {pr_v_r[1:0], rot_v[0]};
    end
    y1_r  <= mulq(sn[2], cs[1]);
    t1_r  <= mulq(cs[0], sn[1]);
    u1_r  <= mulq(sn[0], cs[1]);
    cd1_r <= cs[2];
    y2_r  <= y1_r;
    t2_r  <= t1_r;
    v2_r  <= mulq(u1_r, cd1_r);
    y3_r  <= y2_r;
    x3_r  <= XW'(t2_r) - XW'(v2_r);
  end

  // ---- atan2 ----
  logic        vec_v;
  logic [31:0] ang;

  gcib_cordic_vec u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pr_v_r[2]),
    .in_x      (x3_r),
    .in_y      (y3_r),
    .out_valid (vec_v),
    .out_angle (ang)
  );

  // ---- turns to truncated degrees, wrapped to 0..359 ----
  logic        dg_v_r;
  logic        dg_neg_r;
  logic [8:0]  dg_m_r;
  logic [31:0] ang_mag;
  logic [40:0] deg_prd;
  logic        out_v_r;
  logic [8:0]  bear_r;

  assign ang_mag = ang[31] ? (-ang) : ang;
  assign deg_prd = 41'(ang_mag) * 41'd360;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dg_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      dg_v_r  <= vec_v;
      out_v_r <= dg_v_r;
    end
    dg_neg_r <= ang[31];
    dg_m_r   <= deg_prd[40:32];
    // negative bearings wrap, minus 180 becomes 180
    bear_r   <= (dg_neg_r && (dg_m_r != '0)) ? (9'd360 - dg_m_r) : dg_m_r;
  end

  assign out_valid       = out_v_r;
  assign out_bearing_deg = bear_r;

  // ---- checks ----
  `GCIB_CHK_IMPLY(a_bearing_range, clk, rst_n, out_valid, out_bearing_deg < 9'd360)
  `GCIB_CHK_IMPLY(a_latency, clk, rst_n, out_valid, $past(acc, LAT))
  `GCIB_CHK_NEXT(a_lanes_enter, clk, rst_n, acc, cv_v_r[0])

endmodule
